// ===== hw/rtl/bem_pkg.sv =====
// ----------------------------------------------------------------------------
// bem_pkg: shared constants and types of the bitmap extent marker
// Window geometry, field widths, result codes and the command/status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package bem_pkg;

  // Window geometry
  localparam int WINDOW_BYTES  = 512;
  localparam int BLK_PER_WIN   = WINDOW_BYTES * 8;
  localparam int WORD_BITS     = 32;
  localparam int WSHIFT        = $clog2(WORD_BITS);
  localparam int BIT_W         = WSHIFT;
  localparam int WORDS         = (BLK_PER_WIN + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W        = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int OFF_W         = $clog2(BLK_PER_WIN + 1);

  // Field widths
  localparam int BLK_W         = 32;
  localparam int WIN_IDX_W     = 20;
  localparam int CNT_W         = 13;
  localparam int TOT_W         = 32;
  localparam int STS_W         = 2;

  // Absolute block arithmetic: holds start+count and (index+1)*window
  localparam int ABS_W = (WIN_IDX_W + OFF_W > BLK_W + 1) ? (WIN_IDX_W + OFF_W) : (BLK_W + 1);

  // Result codes
  localparam logic [STS_W-1:0] ST_MARKED  = 2'd0;
  localparam logic [STS_W-1:0] ST_OUTSIDE = 2'd1;
  localparam logic [STS_W-1:0] ST_OVERLAP = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // load a new item
    logic wi_first;  // point the word index at the first covered word
    logic rd;        // read the word at the index and advance
    logic set_pass;  // the read belongs to the set pass
    logic clr_wr;    // write a zero word at the index and advance
    logic finish;    // load the result and update the totals
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;  // index is at the last word of the store
    logic wi_last;   // index is at the last covered word
    logic nonempty;  // clipped extent covers at least one block
    logic hit;       // check pass found a set bit
    logic out_free;  // result register can take a new result
  } dp_sts_t;

endpackage

// ===== hw/rtl/bem_dpath.sv =====
// ----------------------------------------------------------------------------
// bem_dpath: datapath of the bitmap extent marker
// Clips the extent to the window, walks the bitmap memory word by word for
// the check and set passes, and holds the counters and the result register.
// ----------------------------------------------------------------------------
module bem_dpath (
  input  logic                         clk,
  input  logic                         rst,
  input  bem_pkg::dp_cmd_t             cmd,
  output bem_pkg::dp_sts_t             sts,
  input  logic                         cfg_valid,
  input  logic [bem_pkg::WIN_IDX_W-1:0] cfg_data,
  input  logic [bem_pkg::BLK_W-1:0]    start_block,
  input  logic [bem_pkg::BLK_W-1:0]    block_count,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bem_pkg::STS_W-1:0]    status,
  output logic [bem_pkg::CNT_W-1:0]    marked_count,
  output logic [bem_pkg::CNT_W-1:0]    window_total,
  output logic [bem_pkg::TOT_W-1:0]    marked_total
);
  import bem_pkg::*;

  logic [WIN_IDX_W-1:0] window_index;
  logic [BLK_W-1:0]     s_q;
  logic [BLK_W-1:0]     c_q;
  logic                 c_zero;
  logic [ABS_W-1:0]     ws;
  logic [ABS_W-1:0]     we;
  logic [ABS_W-1:0]     e;
  logic [ABS_W-1:0]     lo;
  logic [ABS_W-1:0]     hi;
  logic [ABS_W-1:0]     s_abs;
  logic                 zero_ok;
  logic [OFF_W-1:0]     lo_off;
  logic [OFF_W-1:0]     hi_off;
  logic [OFF_W-1:0]     hi_m1;
  logic [OFF_W-1:0]     len;
  logic                 nonempty;
  logic [WIDX_W-1:0]    wi;
  logic [WIDX_W-1:0]    first_word;
  logic [WIDX_W-1:0]    last_word;
  logic [BIT_W-1:0]     lo_bit;
  logic [BIT_W-1:0]     hi_bit;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] mask_q;
  logic [WIDX_W-1:0]    addr_q;
  logic [WORD_BITS-1:0] rdata;
  logic                 pend_chk;
  logic                 pend_set;
  logic                 hit;
  logic                 mem_we;
  logic [WIDX_W-1:0]    waddr;
  logic [WORD_BITS-1:0] wdata;
  logic [CNT_W-1:0]     window_counter;
  logic [TOT_W-1:0]     total_counter;
  logic [CNT_W-1:0]     window_counter_next;
  logic [TOT_W-1:0]     total_counter_next;
  logic                 mark_ok;

  logic [WORD_BITS-1:0] mem [WORDS];

  // Hold the window register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_index <= '0;
    end else if (cfg_valid) begin
      window_index <= cfg_data;
    end
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      s_q    <= start_block;
      c_q    <= block_count;
      c_zero <= (block_count == '0);
    end
  end

  // Clip the extent to the window; each stage settles in the cycle after the stage before it
  assign s_abs = ABS_W'(s_q);

  always_ff @(posedge clk) begin
    ws       <= ABS_W'(window_index) * ABS_W'(BLK_PER_WIN);
    e        <= s_abs + ABS_W'(c_q);
    we       <= ws + ABS_W'(BLK_PER_WIN);
    lo       <= (s_abs > ws) ? s_abs : ws;
    hi       <= (e < we) ? e : we;
    zero_ok  <= c_zero && (s_abs >= ws) && (s_abs < we);
    lo_off   <= OFF_W'(lo - ws);
    hi_off   <= OFF_W'(hi - ws);
    nonempty <= (hi > lo);
    len      <= hi_off - lo_off;
  end

  // Word range and bit mask of the word at the index
  assign hi_m1      = hi_off - 1'b1;
  assign first_word = WIDX_W'(lo_off >> WSHIFT);
  assign last_word  = WIDX_W'(hi_m1 >> WSHIFT);
  assign lo_bit     = (wi == first_word) ? BIT_W'(lo_off % WORD_BITS) : '0;
  assign hi_bit     = (wi == last_word) ? BIT_W'(hi_m1 % WORD_BITS) : BIT_W'(WORD_BITS - 1);

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      mask[i] = (BIT_W'(i) >= lo_bit) && (BIT_W'(i) <= hi_bit);
    end
  end

  // Advance the word index
  always_ff @(posedge clk) begin
    if (rst) begin
      wi <= '0;
    end else if (cmd.wi_first) begin
      wi <= first_word;
    end else if (cmd.rd || cmd.clr_wr) begin
      wi <= wi + 1'b1;
    end
  end

  // Track outstanding reads
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_chk <= 1'b0;
      pend_set <= 1'b0;
    end else begin
      pend_chk <= cmd.rd && !cmd.set_pass;
      pend_set <= cmd.rd && cmd.set_pass;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      mask_q <= mask;
      addr_q <= wi;
    end
  end

  // Bitmap memory: one write and one registered read a cycle
  assign mem_we = cmd.clr_wr || pend_set;
  assign waddr  = cmd.clr_wr ? wi : addr_q;
  assign wdata  = cmd.clr_wr ? '0 : (rdata | mask_q);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd) begin
      rdata <= mem[wi];
    end
  end

  // Collect overlaps over the check pass
  always_ff @(posedge clk) begin
    if (rst || cmd.capture) begin
      hit <= 1'b0;
    end else if (pend_chk && ((rdata & mask_q) != '0)) begin
      hit <= 1'b1;
    end
  end

  // Counters and result register
  assign mark_ok             = nonempty && !hit;
  assign window_counter_next = window_counter + CNT_W'(len);
  assign total_counter_next  = total_counter + TOT_W'(len);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_counter <= '0;
      total_counter  <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.finish && mark_ok) begin
        window_counter <= window_counter_next;
        total_counter  <= total_counter_next;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (!nonempty) begin
        status <= zero_ok ? ST_MARKED : ST_OUTSIDE;
      end else if (hit) begin
        status <= ST_OVERLAP;
      end else begin
        status <= ST_MARKED;
      end
      marked_count <= mark_ok ? CNT_W'(len) : '0;
      window_total <= mark_ok ? window_counter_next : window_counter;
      marked_total <= mark_ok ? total_counter_next : total_counter;
    end
  end

  // Status to the controller
  assign sts.clr_last = (wi == WIDX_W'(WORDS - 1));
  assign sts.wi_last  = (wi == last_word);
  assign sts.nonempty = nonempty;
  assign sts.hit      = hit;
  assign sts.out_free = !out_valid || !out_stall;

  // Set-pass writes stay inside the covered words
  a_set_range: assert property (@(posedge clk) disable iff (rst)
    pend_set |-> (addr_q >= first_word) && (addr_q <= last_word))
    else $error("set write outside covered words");

  // An overlap leaves nothing marked
  a_overlap: assert property (@(posedge clk) disable iff (rst)
    cmd.finish && nonempty && hit |=> out_valid && (status == ST_OVERLAP) &&
      (marked_count == '0))
    else $error("overlap result marked blocks");

  // A marked extent adds its length to the running total
  a_total: assert property (@(posedge clk) disable iff (rst)
    cmd.finish && nonempty && !hit |=>
      marked_total == $past(total_counter) + TOT_W'($past(len)))
    else $error("running total not advanced by extent length");

endmodule

// ===== hw/rtl/bem_ctrl.sv =====
// ----------------------------------------------------------------------------
// bem_ctrl: sequencer of the bitmap extent marker
// Runs the clearing pass after reset, then per item the clip wait, the check
// pass if it touches the window, the set pass if no overlap, and the hand-off.
// ----------------------------------------------------------------------------
module bem_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output bem_pkg::dp_cmd_t cmd,
  input  bem_pkg::dp_sts_t sts
);
  import bem_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CLIP_A,
    S_CLIP_B,
    S_CLIP_C,
    S_CLIP_D,
    S_DECIDE,
    S_CHK_RUN,
    S_CHK_DRAIN,
    S_SET_START,
    S_SET_RUN,
    S_SET_DRAIN,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  // Decode commands and next state
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_CLIP_A;
        end
      end
      S_CLIP_A: state_next = S_CLIP_B;
      S_CLIP_B: state_next = S_CLIP_C;
      S_CLIP_C: state_next = S_CLIP_D;
      S_CLIP_D: state_next = S_DECIDE;
      S_DECIDE: begin
        if (sts.nonempty) begin
          cmd.wi_first = 1'b1;
          state_next   = S_CHK_RUN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_CHK_RUN: begin
        cmd.rd = 1'b1;
        if (sts.wi_last) state_next = S_CHK_DRAIN;
      end
      S_CHK_DRAIN: state_next = S_SET_START;
      S_SET_START: begin
        if (sts.hit) begin
          state_next = S_DONE;
        end else begin
          cmd.wi_first = 1'b1;
          state_next   = S_SET_RUN;
        end
      end
      S_SET_RUN: begin
        cmd.rd       = 1'b1;
        cmd.set_pass = 1'b1;
        if (sts.wi_last) state_next = S_SET_DRAIN;
      end
      S_SET_DRAIN: state_next = S_DONE;
      S_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // The set pass never runs after an overlap
  a_no_set_on_hit: assert property (@(posedge clk) disable iff (rst)
    (state == S_SET_RUN) |-> !sts.hit)
    else $error("set pass after overlap");

  // A result is loaded only when the result register is free
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> sts.out_free)
    else $error("result loaded over a pending result");

  // Memory passes run only for extents that touch the window
  a_rd_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |-> sts.nonempty && !in_stall == 1'b0)
    else $error("memory pass for an empty extent");

endmodule

// ===== hw/rtl/bitmap_extent_marker.sv =====
// ----------------------------------------------------------------------------
// bitmap_extent_marker: marks extents of allocation blocks in a bitmap window
// Input channel (in_valid/in_stall) takes an extent as start_block and
// block_count. Output channel (out_valid/out_stall) returns one result per
// extent: status, marked_count, window_total and marked_total.
// The cfg channel (cfg_valid/cfg_ready) writes window_index; write it only
// while no item is in flight. cfg_ready is always high.
// Each item passes the clip states and a decide state. An extent that touches
// the window then runs a check pass and a set pass over the n bitmap words it
// spans, a turn-around state between the passes and a hand-off state that
// loads the result; the next item is taken only after the hand-off. An overlap
// skips the set pass; an extent outside the window goes straight from the
// decide state to the hand-off. The single read port of the bitmap memory sets
// the pass length.
// After reset a clearing pass zeroes the 128 bitmap words, one per cycle;
// in_stall stays high meanwhile, while cfg writes are taken as usual.
// A finished result waits in the output register while out_stall is high;
// the next item is taken meanwhile and holds only at its own hand-off.
// ----------------------------------------------------------------------------
module bitmap_extent_marker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bem_pkg::WIN_IDX_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bem_pkg::BLK_W-1:0]     start_block,
  input  logic [bem_pkg::BLK_W-1:0]     block_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bem_pkg::STS_W-1:0]     status,
  output logic [bem_pkg::CNT_W-1:0]     marked_count,
  output logic [bem_pkg::CNT_W-1:0]     window_total,
  output logic [bem_pkg::TOT_W-1:0]     marked_total
);
  import bem_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Accept window writes at any time
  assign cfg_ready = 1'b1;

  bem_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  bem_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .start_block  (start_block),
    .block_count  (block_count),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .marked_count (marked_count),
    .window_total (window_total),
    .marked_total (marked_total)
  );

endmodule
